FILE: hw/rtl/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg
// Shared types and constants for the lattice birth/death update block.
// ----------------------------------------------------------------------------
package lbd_pkg;

  localparam int LBD_MAX_SIDE    = 128;
  localparam int LBD_MAX_SPECIES = 1024;
  localparam int LBD_MAX_RADIUS  = 15;

  localparam int CMD_W     = 3;
  localparam int COORD_W   = 8;
  localparam int SPECIES_W = 10;
  localparam int INDEX_W   = 15;
  localparam int DRAW_W    = 16;
  localparam int OFFSET_W  = 5;
  localparam int PROB_W    = 17;
  localparam int RADIUS_W  = 4;
  localparam int STATUS_W  = 4;
  localparam int COUNT_W   = 15;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_UPDATE  = 3'd1,
    CMD_WR_PROB = 3'd2,
    CMD_WR_BRAD = 3'd3,
    CMD_WR_CRAD = 3'd4
  } lbd_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_DIED      = 4'd0,
    RS_BORN      = 4'd1,
    RS_BLOCKED   = 4'd2,
    RS_COAG      = 4'd3,
    RS_COAG_MISS = 4'd4,
    RS_IDLE      = 4'd5,
    RS_REJECT    = 4'd6,
    RS_INSERTED  = 4'd7,
    RS_OCCUPIED  = 4'd8,
    RS_BAD_INDEX = 4'd9,
    RS_TABLE     = 4'd10,
    RS_FULL      = 4'd11
  } lbd_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_INS_CHK,
    ST_LIST,
    ST_SITE,
    ST_SPEC,
    ST_WRAP,
    ST_NBR,
    ST_REM_RD,
    ST_REM_WR,
    ST_DONE
  } lbd_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic [SPECIES_W-1:0]       species;
    logic [INDEX_W-1:0]         list_index;
    logic [DRAW_W-1:0]          draw;
    logic signed [OFFSET_W-1:0] offset_row;
    logic signed [OFFSET_W-1:0] offset_col;
    logic [PROB_W-1:0]          prob_death;
    logic [PROB_W-1:0]          prob_birth;
    logic [PROB_W-1:0]          prob_coag;
    logic [RADIUS_W-1:0]        radius;
  } lbd_item_t;

  typedef struct packed {
    lbd_status_t        status;
    logic [COUNT_W-1:0] occupied_count;
    logic [COORD_W-1:0] target_row;
    logic [COORD_W-1:0] target_col;
  } lbd_res_t;

endpackage

FILE: hw/rtl/lbd_in_if.sv
// ----------------------------------------------------------------------------
// lbd_in_if
// Command channel: valid/ready handshake with one command item.
// ----------------------------------------------------------------------------
interface lbd_in_if;
  import lbd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic [COORD_W-1:0]         row;
  logic [COORD_W-1:0]         col;
  logic [SPECIES_W-1:0]       species;
  logic [INDEX_W-1:0]         list_index;
  logic [DRAW_W-1:0]          draw;
  logic signed [OFFSET_W-1:0] offset_row;
  logic signed [OFFSET_W-1:0] offset_col;
  logic [PROB_W-1:0]          prob_death;
  logic [PROB_W-1:0]          prob_birth;
  logic [PROB_W-1:0]          prob_coag;
  logic [RADIUS_W-1:0]        radius;

  modport source (
    output valid, cmd, row, col, species, list_index, draw, offset_row, offset_col,
           prob_death, prob_birth, prob_coag, radius,
    input  ready
  );

  modport sink (
    input  valid, cmd, row, col, species, list_index, draw, offset_row, offset_col,
           prob_death, prob_birth, prob_coag, radius,
    output ready
  );
endinterface

FILE: hw/rtl/lbd_out_if.sv
// ----------------------------------------------------------------------------
// lbd_out_if
// Result channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface lbd_out_if;
  import lbd_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  occupied_count;
  logic [COORD_W-1:0]  target_row;
  logic [COORD_W-1:0]  target_col;

  modport source (
    output valid, status, occupied_count, target_row, target_col,
    input  ready
  );

  modport sink (
    input  valid, status, occupied_count, target_row, target_col,
    output ready
  );
endinterface

FILE: hw/rtl/lbd_ram.sv
// ----------------------------------------------------------------------------
// lbd_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: hw/rtl/lbd_wrap.sv
// ----------------------------------------------------------------------------
// lbd_wrap
// Iterative toroidal wrap: reduces row and column sums into the grid by
// repeated add or subtract of the grid side, one step per cycle.
// ----------------------------------------------------------------------------
module lbd_wrap #(
  parameter int MAX_SIDE = lbd_pkg::LBD_MAX_SIDE
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [$clog2(MAX_SIDE)-1:0]         base_row,
  input  logic [$clog2(MAX_SIDE)-1:0]         base_col,
  input  logic signed [lbd_pkg::OFFSET_W-1:0] off_row,
  input  logic signed [lbd_pkg::OFFSET_W-1:0] off_col,
  input  logic [$clog2(MAX_SIDE):0]           grid_rows,
  input  logic [$clog2(MAX_SIDE):0]           grid_cols,
  output logic                                done,
  output logic [$clog2(MAX_SIDE)-1:0]         wrap_row,
  output logic [$clog2(MAX_SIDE)-1:0]         wrap_col
);
  import lbd_pkg::*;

  localparam int CW = $clog2(MAX_SIDE);
  localparam int WW = CW + 7;

  logic                 busy_r, busy_nxt;
  logic signed [WW-1:0] a_r, a_nxt;
  logic signed [WW-1:0] b_r, b_nxt;
  logic signed [WW-1:0] side_r, side_c;
  logic                 a_ok, b_ok;

  assign side_r = WW'($signed({1'b0, grid_rows}));
  assign side_c = WW'($signed({1'b0, grid_cols}));
  assign a_ok   = (a_r >= 0) && (a_r < side_r);
  assign b_ok   = (b_r >= 0) && (b_r < side_c);
  assign done   = busy_r && a_ok && b_ok;

  assign wrap_row = a_r[CW-1:0];
  assign wrap_col = b_r[CW-1:0];

  always_comb begin
    busy_nxt = busy_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = WW'($signed({1'b0, base_row})) + WW'(off_row);
      b_nxt    = WW'($signed({1'b0, base_col})) + WW'(off_col);
    end else if (busy_r) begin
      if (done) begin
        busy_nxt = 1'b0;
      end
      if (a_r < 0) begin
        a_nxt = a_r + side_r;
      end else if (a_r >= side_r) begin
        a_nxt = a_r - side_r;
      end
      if (b_r < 0) begin
        b_nxt = b_r + side_c;
      end else if (b_r >= side_c) begin
        b_nxt = b_r - side_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
  end
endmodule

FILE: hw/rtl/lbd_ctrl.sv
// ----------------------------------------------------------------------------
// lbd_ctrl
// Command sequencer around the site, list and species memories: reads,
// decides and writes back one command at a time.
// ----------------------------------------------------------------------------
module lbd_ctrl #(
  parameter int MAX_SIDE    = lbd_pkg::LBD_MAX_SIDE,
  parameter int MAX_SPECIES = lbd_pkg::LBD_MAX_SPECIES,
  parameter int MAX_RADIUS  = lbd_pkg::LBD_MAX_RADIUS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [$clog2(MAX_SIDE):0] grid_rows,
  input  logic [$clog2(MAX_SIDE):0] grid_cols,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  lbd_pkg::lbd_item_t        item,
  output logic                      res_valid,
  input  logic                      res_ready,
  output lbd_pkg::lbd_res_t         res
);
  import lbd_pkg::*;

  localparam int CW     = $clog2(MAX_SIDE);
  localparam int SW     = 2 * CW;
  localparam int SD     = 2 ** SW;
  localparam int NSITES = MAX_SIDE * MAX_SIDE;
  localparam int LW     = $clog2(NSITES);
  localparam int TW     = $clog2(NSITES + 1);
  localparam int IW     = (TW > INDEX_W) ? TW : INDEX_W;
  localparam int SPW    = $clog2(MAX_SPECIES);
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int QW     = (2 * RW + 1 > 11) ? 2 * RW + 1 : 11;
  localparam int CLN    = (SD > MAX_SPECIES) ? SD : MAX_SPECIES;
  localparam int CLW    = $clog2(CLN) + 1;
  localparam int PW     = 3 * PROB_W;

  lbd_state_t        state_r, state_nxt;
  lbd_item_t         item_r;
  logic [CLW-1:0]    clr_r, clr_nxt;
  logic [TW-1:0]     total_r, total_nxt;
  logic [CW-1:0]     cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [CW-1:0]     tgt_row_r, tgt_row_nxt, tgt_col_r, tgt_col_nxt;
  logic [SPW-1:0]    sp_r, sp_nxt;
  logic [LW-1:0]     pos_r, pos_nxt;
  logic              birth_r, birth_nxt;
  logic              has_r, has_nxt;
  lbd_status_t       status_r, status_nxt;

  logic              site_we;
  logic [SW-1:0]     site_waddr, site_raddr;
  logic [SPW:0]      site_wdata, site_rdata;
  logic              pos_we;
  logic [SW-1:0]     pos_waddr;
  logic [LW-1:0]     pos_wdata, pos_rdata;
  logic              list_we;
  logic [LW-1:0]     list_waddr, list_raddr;
  logic [SW-1:0]     list_wdata, list_rdata;
  logic              prob_we, brad_we, crad_we;
  logic [SPW-1:0]    spec_waddr, spec_raddr;
  logic [PW-1:0]     prob_wdata, prob_rdata;
  logic [RW-1:0]     rad_wdata, brad_rdata, crad_rdata;

  logic              append, remove;
  logic              wrap_start, wrap_done;
  logic [CW-1:0]     wrap_row, wrap_col;

  logic [CW-1:0]     ins_row, ins_col;
  logic              ins_bad, sp_big, idx_bad;
  logic [SPW-1:0]    sp_in;
  logic [IW-1:0]     idx_m1;
  logic [PROB_W-1:0] pd_in, pb_in, pc_in;
  logic [RW-1:0]     rad_in;
  logic [PROB_W-1:0] th_d;
  logic [PROB_W:0]   th_db;
  logic [PROB_W+1:0] th_dbc;
  logic signed [QW-1:0] dr_x, dc_x, r2;
  logic [QW-1:0]     rad_x, rad_sq;
  logic              off_bad;
  logic [TW-1:0]     total_m1;
  logic [COORD_W-1:0] row_m1, col_m1;
  logic [COORD_W:0]  trow_p1, tcol_p1;

  function automatic logic [PROB_W-1:0] sat_prob(input logic [PROB_W-1:0] p);
    sat_prob = (p > PROB_ONE) ? PROB_ONE : p;
  endfunction

  lbd_ram #(.WIDTH(SPW + 1), .DEPTH(SD)) u_site_ram (
    .clk(clk), .we(site_we), .waddr(site_waddr), .wdata(site_wdata),
    .raddr(site_raddr), .rdata(site_rdata)
  );

  lbd_ram #(.WIDTH(LW), .DEPTH(SD)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(site_raddr), .rdata(pos_rdata)
  );

  lbd_ram #(.WIDTH(SW), .DEPTH(NSITES)) u_list_ram (
    .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
    .raddr(list_raddr), .rdata(list_rdata)
  );

  lbd_ram #(.WIDTH(PW), .DEPTH(MAX_SPECIES)) u_prob_ram (
    .clk(clk), .we(prob_we), .waddr(spec_waddr), .wdata(prob_wdata),
    .raddr(spec_raddr), .rdata(prob_rdata)
  );

  lbd_ram #(.WIDTH(RW), .DEPTH(MAX_SPECIES)) u_brad_ram (
    .clk(clk), .we(brad_we), .waddr(spec_waddr), .wdata(rad_wdata),
    .raddr(spec_raddr), .rdata(brad_rdata)
  );

  lbd_ram #(.WIDTH(RW), .DEPTH(MAX_SPECIES)) u_crad_ram (
    .clk(clk), .we(crad_we), .waddr(spec_waddr), .wdata(rad_wdata),
    .raddr(spec_raddr), .rdata(crad_rdata)
  );

  lbd_wrap #(.MAX_SIDE(MAX_SIDE)) u_wrap (
    .clk(clk), .rst_n(rst_n), .start(wrap_start),
    .base_row(cur_row_r), .base_col(cur_col_r),
    .off_row(item_r.offset_row), .off_col(item_r.offset_col),
    .grid_rows(grid_rows), .grid_cols(grid_cols),
    .done(wrap_done), .wrap_row(wrap_row), .wrap_col(wrap_col)
  );

  assign row_m1  = item_r.row - COORD_W'(1);
  assign col_m1  = item_r.col - COORD_W'(1);
  assign ins_row = row_m1[CW-1:0];
  assign ins_col = col_m1[CW-1:0];
  assign sp_big  = 13'(item_r.species) >= 13'(MAX_SPECIES);
  assign sp_in   = SPW'(item_r.species);
  assign ins_bad = (item_r.row == '0) || (9'(item_r.row) > 9'(grid_rows)) ||
                   (item_r.col == '0) || (9'(item_r.col) > 9'(grid_cols)) || sp_big;
  assign idx_bad = (item_r.list_index == '0) || (IW'(item_r.list_index) > IW'(total_r));
  assign idx_m1  = IW'(item_r.list_index) - IW'(1);
  assign total_m1 = total_r - TW'(1);

  assign pd_in  = sat_prob(item_r.prob_death);
  assign pb_in  = sat_prob(item_r.prob_birth);
  assign pc_in  = sat_prob(item_r.prob_coag);
  assign rad_in = (7'(item_r.radius) > 7'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(item_r.radius);

  assign th_d   = prob_rdata[PW-1 -: PROB_W];
  assign th_db  = (PROB_W + 1)'(th_d) + (PROB_W + 1)'(prob_rdata[2*PROB_W-1 -: PROB_W]);
  assign th_dbc = (PROB_W + 2)'(th_db) + (PROB_W + 2)'(prob_rdata[PROB_W-1:0]);

  assign dr_x   = QW'($signed(item_r.offset_row));
  assign dc_x   = QW'($signed(item_r.offset_col));
  assign r2     = dr_x * dr_x + dc_x * dc_x;
  assign rad_x  = (item_r.draw <= th_db) ? QW'(brad_rdata) : QW'(crad_rdata);
  assign rad_sq = rad_x * rad_x;
  assign off_bad = (r2 == '0) || ($unsigned(r2) > rad_sq);

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    total_nxt   = total_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    tgt_row_nxt = tgt_row_r;
    tgt_col_nxt = tgt_col_r;
    sp_nxt      = sp_r;
    pos_nxt     = pos_r;
    birth_nxt   = birth_r;
    has_nxt     = has_r;
    status_nxt  = status_r;
    item_ready  = 1'b0;
    res_valid   = 1'b0;
    wrap_start  = 1'b0;
    append      = 1'b0;
    remove      = 1'b0;
    site_we     = 1'b0;
    site_waddr  = {tgt_row_r, tgt_col_r};
    site_wdata  = '0;
    site_raddr  = {tgt_row_r, tgt_col_r};
    pos_we      = 1'b0;
    pos_waddr   = {tgt_row_r, tgt_col_r};
    pos_wdata   = total_r[LW-1:0];
    list_we     = 1'b0;
    list_waddr  = total_r[LW-1:0];
    list_wdata  = {tgt_row_r, tgt_col_r};
    list_raddr  = total_m1[LW-1:0];
    prob_we     = 1'b0;
    brad_we     = 1'b0;
    crad_we     = 1'b0;
    spec_waddr  = sp_in;
    spec_raddr  = site_rdata[SPW-1:0];
    prob_wdata  = {pd_in, pb_in, pc_in};
    rad_wdata   = rad_in;

    case (state_r)
      ST_CLEAR: begin
        site_we    = clr_r < CLW'(SD);
        site_waddr = clr_r[SW-1:0];
        spec_waddr = clr_r[SPW-1:0];
        prob_wdata = '0;
        rad_wdata  = '0;
        prob_we    = clr_r < CLW'(MAX_SPECIES);
        brad_we    = prob_we;
        crad_we    = prob_we;
        clr_nxt    = clr_r + CLW'(1);
        if (clr_r == CLW'(CLN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        has_nxt   = 1'b0;
        state_nxt = ST_DONE;
        case (lbd_cmd_t'(item_r.cmd))
          CMD_INSERT: begin
            if (ins_bad) begin
              status_nxt = RS_BAD_INDEX;
            end else begin
              tgt_row_nxt = ins_row;
              tgt_col_nxt = ins_col;
              has_nxt     = 1'b1;
              sp_nxt      = sp_in;
              site_raddr  = {ins_row, ins_col};
              state_nxt   = ST_INS_CHK;
            end
          end
          CMD_UPDATE: begin
            if (idx_bad) begin
              status_nxt = RS_BAD_INDEX;
            end else begin
              list_raddr = idx_m1[LW-1:0];
              state_nxt  = ST_LIST;
            end
          end
          CMD_WR_PROB, CMD_WR_BRAD, CMD_WR_CRAD: begin
            if (sp_big) begin
              status_nxt = RS_BAD_INDEX;
            end else begin
              prob_we    = lbd_cmd_t'(item_r.cmd) == CMD_WR_PROB;
              brad_we    = lbd_cmd_t'(item_r.cmd) == CMD_WR_BRAD;
              crad_we    = lbd_cmd_t'(item_r.cmd) == CMD_WR_CRAD;
              status_nxt = RS_TABLE;
            end
          end
          default: begin
            status_nxt = RS_IDLE;
          end
        endcase
      end
      ST_INS_CHK: begin
        state_nxt = ST_DONE;
        if (site_rdata[SPW]) begin
          status_nxt = RS_OCCUPIED;
        end else if (total_r >= TW'(NSITES)) begin
          status_nxt = RS_FULL;
        end else begin
          append     = 1'b1;
          status_nxt = RS_INSERTED;
        end
      end
      ST_LIST: begin
        cur_row_nxt = list_rdata[SW-1:CW];
        cur_col_nxt = list_rdata[CW-1:0];
        site_raddr  = list_rdata;
        state_nxt   = ST_SITE;
      end
      ST_SITE: begin
        sp_nxt    = site_rdata[SPW-1:0];
        pos_nxt   = pos_rdata;
        state_nxt = ST_SPEC;
      end
      ST_SPEC: begin
        state_nxt = ST_DONE;
        if (19'(item_r.draw) <= 19'(th_d)) begin
          tgt_row_nxt = cur_row_r;
          tgt_col_nxt = cur_col_r;
          has_nxt     = 1'b1;
          status_nxt  = RS_DIED;
          state_nxt   = ST_REM_RD;
        end else if (19'(item_r.draw) <= 19'(th_dbc)) begin
          birth_nxt = 19'(item_r.draw) <= 19'(th_db);
          if (off_bad) begin
            status_nxt = RS_REJECT;
          end else begin
            wrap_start = 1'b1;
            state_nxt  = ST_WRAP;
          end
        end else begin
          status_nxt = RS_IDLE;
        end
      end
      ST_WRAP: begin
        if (wrap_done) begin
          tgt_row_nxt = wrap_row;
          tgt_col_nxt = wrap_col;
          has_nxt     = 1'b1;
          site_raddr  = {wrap_row, wrap_col};
          state_nxt   = ST_NBR;
        end
      end
      ST_NBR: begin
        state_nxt = ST_DONE;
        if (birth_r) begin
          if (site_rdata[SPW]) begin
            status_nxt = RS_BLOCKED;
          end else begin
            append     = 1'b1;
            status_nxt = RS_BORN;
          end
        end else if (!site_rdata[SPW]) begin
          status_nxt = RS_COAG_MISS;
        end else begin
          pos_nxt    = pos_rdata;
          status_nxt = RS_COAG;
          state_nxt  = ST_REM_RD;
        end
      end
      ST_REM_RD: begin
        state_nxt = ST_REM_WR;
      end
      ST_REM_WR: begin
        remove    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (append) begin
      site_we    = 1'b1;
      site_wdata = {1'b1, sp_r};
      list_we    = 1'b1;
      pos_we     = 1'b1;
      total_nxt  = total_r + TW'(1);
    end
    if (remove) begin
      list_we    = 1'b1;
      list_waddr = pos_r;
      list_wdata = list_rdata;
      pos_we     = 1'b1;
      pos_waddr  = list_rdata;
      pos_wdata  = pos_r;
      site_we    = 1'b1;
      site_wdata = '0;
      total_nxt  = total_m1;
    end
  end

  assign trow_p1 = (COORD_W + 1)'(tgt_row_r) + (COORD_W + 1)'(1);
  assign tcol_p1 = (COORD_W + 1)'(tgt_col_r) + (COORD_W + 1)'(1);

  assign res.status         = status_r;
  assign res.occupied_count = COUNT_W'(total_r);
  assign res.target_row     = has_r ? trow_p1[COORD_W-1:0] : '0;
  assign res.target_col     = has_r ? tcol_p1[COORD_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      total_r <= total_nxt;
    end
    if (item_valid && item_ready) begin
      item_r <= item;
    end
    cur_row_r <= cur_row_nxt;
    cur_col_r <= cur_col_nxt;
    tgt_row_r <= tgt_row_nxt;
    tgt_col_r <= tgt_col_nxt;
    sp_r      <= sp_nxt;
    pos_r     <= pos_nxt;
    birth_r   <= birth_nxt;
    has_r     <= has_nxt;
    status_r  <= status_nxt;
  end
endmodule

FILE: hw/rtl/lattice_birth_death_update.sv
// ----------------------------------------------------------------------------
// lattice_birth_death_update
// Toroidal lattice of sites with a dense occupied list; inserts, updates
// individuals by death, birth or coagulation, and writes species tables.
// Commands are processed one at a time through the memory read-modify-write
// chain; a new item is not accepted until the previous result has been handed
// to the output register. An update to a wrapped neighbor also waits for the
// wrap unit to bring the row and column into the grid.
// Reset: a clearing pass sweeps the site and species memories before the first transfer.
// ----------------------------------------------------------------------------
module lattice_birth_death_update #(
  parameter int MAX_SIDE    = lbd_pkg::LBD_MAX_SIDE,
  parameter int MAX_SPECIES = lbd_pkg::LBD_MAX_SPECIES,
  parameter int MAX_RADIUS  = lbd_pkg::LBD_MAX_RADIUS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lbd_in_if.sink                            in_ch,
  lbd_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [lbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lbd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import lbd_pkg::*;

  localparam int CW       = $clog2(MAX_SIDE);
  localparam int GRID_RST = (MAX_SIDE < 128) ? MAX_SIDE : 128;

  logic [CW:0]   grid_rows_r, grid_cols_r, side_clamped;
  lbd_item_t     item;
  lbd_res_t      res;
  logic          res_valid, res_ready;
  logic          out_valid_r;
  lbd_res_t      out_r;

  assign side_clamped = (9'(cfg_wdata) < 9'd2)         ? (CW + 1)'(2) :
                        (9'(cfg_wdata) > 9'(MAX_SIDE)) ? (CW + 1)'(MAX_SIDE) :
                                                          (CW + 1)'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= (CW + 1)'(GRID_RST);
      grid_cols_r <= (CW + 1)'(GRID_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS: grid_rows_r <= side_clamped;
        REG_GRID_COLS: grid_cols_r <= side_clamped;
        default: ;
      endcase
    end
  end

  assign item.cmd        = in_ch.cmd;
  assign item.row        = in_ch.row;
  assign item.col        = in_ch.col;
  assign item.species    = in_ch.species;
  assign item.list_index = in_ch.list_index;
  assign item.draw       = in_ch.draw;
  assign item.offset_row = in_ch.offset_row;
  assign item.offset_col = in_ch.offset_col;
  assign item.prob_death = in_ch.prob_death;
  assign item.prob_birth = in_ch.prob_birth;
  assign item.prob_coag  = in_ch.prob_coag;
  assign item.radius     = in_ch.radius;

  lbd_ctrl #(
    .MAX_SIDE(MAX_SIDE), .MAX_SPECIES(MAX_SPECIES), .MAX_RADIUS(MAX_RADIUS)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .grid_rows(grid_rows_r), .grid_cols(grid_cols_r),
    .item_valid(in_ch.valid), .item_ready(in_ch.ready), .item(item),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.occupied_count = out_r.occupied_count;
  assign out_ch.target_row     = out_r.target_row;
  assign out_ch.target_col     = out_r.target_col;
endmodule

FILE: verif/lbd_tb_if.sv
// ----------------------------------------------------------------------------
// lbd_tb_if
// Testbench-side package for the lattice update channels: holds the expected-result
// type; the RTL interfaces are instantiated directly by the testbench top.
// ----------------------------------------------------------------------------
package lbd_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  import lbd_pkg::*;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [COORD_W-1:0]  trow;
    logic [COORD_W-1:0]  tcol;
  } lbd_expect_t;
endpackage

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lattice_birth_death_update: a behavioral lattice
// predictor tracks sites, the occupied list and species tables, and every
// result transfer is compared field by field against the predicted queue.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbd_pkg::*;
  import lbd_tb_pkg::*;

  localparam int NSITE = LBD_MAX_SIDE * LBD_MAX_SIDE;
  localparam int WATCHDOG = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lbd_in_if  in_ch();
  lbd_out_if out_ch();

  lattice_birth_death_update u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial forever #2 clk = ~clk;

  int rows_used, cols_used;
  bit occ [NSITE];
  int sp_of [NSITE];
  int pos_of [NSITE];
  int occ_list [NSITE];
  int n_occ;
  int p_death [LBD_MAX_SPECIES];
  int p_birth [LBD_MAX_SPECIES];
  int p_coag [LBD_MAX_SPECIES];
  int r_birth [LBD_MAX_SPECIES];
  int r_coag [LBD_MAX_SPECIES];

  lbd_expect_t pending_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  bit timed_out = 0;
  int status_hits [12];

  function automatic int clamp_side(int v);
    return v < 2 ? 2 : (v > LBD_MAX_SIDE ? LBD_MAX_SIDE : v);
  endfunction

  function automatic int wrap(int z, int off, int side);
    int t;
    t = (z + off) % side;
    if (t < 0) t += side;
    return t;
  endfunction

  function automatic void vacate(int s);
    int p, last;
    p = pos_of[s];
    last = occ_list[n_occ - 1];
    occ_list[p] = last;
    pos_of[last] = p;
    n_occ--;
    occ[s] = 0;
    sp_of[s] = 0;
  endfunction

  function automatic void occupy(int s, int sp);
    occ[s] = 1;
    sp_of[s] = sp;
    occ_list[n_occ] = s;
    pos_of[s] = n_occ;
    n_occ++;
  endfunction

  function automatic lbd_expect_t predict_lattice(lbd_item_t it);
    lbd_expect_t e;
    int st, s, sp, idx, dr, dc, pd, pdb, pdbc, rad, nb, r2;
    bit hit, birth;
    hit = 0; s = 0; st = RS_IDLE;
    sp = it.species;
    case (it.cmd)
      CMD_INSERT: begin
        if (it.row == 0 || it.row > rows_used || it.col == 0 || it.col > cols_used)
          st = RS_BAD_INDEX;
        else begin
          s = (it.row - 1) * LBD_MAX_SIDE + (it.col - 1);
          hit = 1;
          if (occ[s]) st = RS_OCCUPIED;
          else if (n_occ >= NSITE) st = RS_FULL;
          else begin
            occupy(s, sp);
            st = RS_INSERTED;
          end
        end
      end
      CMD_UPDATE: begin
        idx = it.list_index;
        dr = it.offset_row;
        dc = it.offset_col;
        if (idx == 0 || idx > n_occ) st = RS_BAD_INDEX;
        else begin
          s = occ_list[idx - 1];
          sp = sp_of[s];
          pd = p_death[sp];
          pdb = pd + p_birth[sp];
          pdbc = pdb + p_coag[sp];
          if (it.draw <= pd) begin
            vacate(s);
            hit = 1;
            st = RS_DIED;
          end else if (it.draw > pdbc) st = RS_IDLE;
          else begin
            birth = it.draw <= pdb;
            rad = birth ? r_birth[sp] : r_coag[sp];
            r2 = dr * dr + dc * dc;
            if (r2 == 0 || r2 > rad * rad) st = RS_REJECT;
            else begin
              nb = wrap(s / LBD_MAX_SIDE, dr, rows_used) * LBD_MAX_SIDE
                 + wrap(s % LBD_MAX_SIDE, dc, cols_used);
              s = nb;
              hit = 1;
              if (birth) begin
                if (occ[nb]) st = RS_BLOCKED;
                else begin
                  occupy(nb, sp);
                  st = RS_BORN;
                end
              end else if (!occ[nb]) st = RS_COAG_MISS;
              else begin
                vacate(nb);
                st = RS_COAG;
              end
            end
          end
        end
      end
      CMD_WR_PROB: begin
        p_death[sp] = it.prob_death > PROB_ONE ? PROB_ONE : it.prob_death;
        p_birth[sp] = it.prob_birth > PROB_ONE ? PROB_ONE : it.prob_birth;
        p_coag[sp] = it.prob_coag > PROB_ONE ? PROB_ONE : it.prob_coag;
        st = RS_TABLE;
      end
      CMD_WR_BRAD: begin
        r_birth[sp] = it.radius;
        st = RS_TABLE;
      end
      CMD_WR_CRAD: begin
        r_coag[sp] = it.radius;
        st = RS_TABLE;
      end
      default: st = RS_IDLE;
    endcase
    e.status = STATUS_W'(st);
    e.count = COUNT_W'(n_occ);
    e.trow = hit ? COORD_W'(s / LBD_MAX_SIDE + 1) : '0;
    e.tcol = hit ? COORD_W'(s % LBD_MAX_SIDE + 1) : '0;
    return e;
  endfunction

  task automatic send_cmd(lbd_item_t it);
    if ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= it.cmd;
    in_ch.row <= it.row;
    in_ch.col <= it.col;
    in_ch.species <= it.species;
    in_ch.list_index <= it.list_index;
    in_ch.draw <= it.draw;
    in_ch.offset_row <= it.offset_row;
    in_ch.offset_col <= it.offset_col;
    in_ch.prob_death <= it.prob_death;
    in_ch.prob_birth <= it.prob_birth;
    in_ch.prob_coag <= it.prob_coag;
    in_ch.radius <= it.radius;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_lattice(it));
    n_sent++;
  endtask

  function automatic lbd_item_t rand_item();
    lbd_item_t it;
    it.cmd = CMD_W'($urandom_range(7));
    it.row = COORD_W'($urandom);
    it.col = COORD_W'($urandom);
    it.species = SPECIES_W'($urandom);
    it.list_index = INDEX_W'($urandom);
    it.draw = DRAW_W'($urandom);
    it.offset_row = OFFSET_W'($urandom);
    it.offset_col = OFFSET_W'($urandom);
    it.prob_death = PROB_W'($urandom);
    it.prob_birth = PROB_W'($urandom);
    it.prob_coag = PROB_W'($urandom);
    it.radius = RADIUS_W'($urandom);
    return it;
  endfunction

  task automatic insert_at(int r, int c, int sp);
    lbd_item_t it;
    it = rand_item();
    it.cmd = CMD_INSERT; it.row = COORD_W'(r); it.col = COORD_W'(c);
    it.species = SPECIES_W'(sp);
    send_cmd(it);
  endtask

  task automatic write_probs(int sp, int d, int b, int c);
    lbd_item_t it;
    it = rand_item();
    it.cmd = CMD_WR_PROB; it.species = SPECIES_W'(sp);
    it.prob_death = PROB_W'(d); it.prob_birth = PROB_W'(b); it.prob_coag = PROB_W'(c);
    send_cmd(it);
  endtask

  task automatic write_radius(lbd_cmd_t which, int sp, int rad);
    lbd_item_t it;
    it = rand_item();
    it.cmd = which; it.species = SPECIES_W'(sp); it.radius = RADIUS_W'(rad);
    send_cmd(it);
  endtask

  task automatic update_at(int idx, int dr_, int dc_, int dv);
    lbd_item_t it;
    it = rand_item();
    it.cmd = CMD_UPDATE; it.list_index = INDEX_W'(idx); it.draw = DRAW_W'(dv);
    it.offset_row = OFFSET_W'(dr_); it.offset_col = OFFSET_W'(dc_);
    send_cmd(it);
  endtask

  task automatic drain_and_settle();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0 && guard < WATCHDOG) begin
      @(posedge clk);
      guard++;
    end
    repeat (3 * LBD_MAX_SIDE) @(posedge clk);
  endtask

  task automatic write_grid(int r, int c);
    drain_and_settle();
    cfg_we <= 1'b1; cfg_index <= REG_GRID_ROWS; cfg_wdata <= CFG_DATA_W'(r);
    @(posedge clk);
    cfg_index <= REG_GRID_COLS; cfg_wdata <= CFG_DATA_W'(c);
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_used = clamp_side(r);
    cols_used = clamp_side(c);
  endtask

  task automatic test_directed();
    write_probs(0, 0, 0, 0);
    insert_at(1, 1, 0);
    insert_at(1, 1, 0);
    insert_at(0, 5, 0);
    insert_at(LBD_MAX_SIDE, LBD_MAX_SIDE, LBD_MAX_SPECIES - 1);
    insert_at(LBD_MAX_SIDE + 1, 1, 0);
    update_at(0, 1, 0, 0);
    update_at(n_occ + 1, 1, 0, 0);
    update_at(1, 1, 0, 1);
    write_probs(1, 'h1FFFF, 0, 0);
    write_probs(2, 0, 65536, 0);
    write_probs(3, 0, 0, 65536);
    write_radius(CMD_WR_BRAD, 2, 15);
    write_radius(CMD_WR_CRAD, 3, 0);
    insert_at(10, 10, 2);
    update_at(n_occ, 0, 0, 100);
    update_at(n_occ, -15, -15, 100);
    update_at(n_occ, -15, 0, 100);
    update_at(n_occ, 15, 0, 100);
    insert_at(20, 20, 3);
    update_at(n_occ, 1, 0, 100);
    write_radius(CMD_WR_CRAD, 3, 15);
    update_at(n_occ, 0, -10, 100);
    update_at(1, 0, 0, 0);
  endtask

  task automatic test_grid_extremes();
    write_grid(2, 2);
    write_radius(CMD_WR_BRAD, 2, 4);
    write_radius(CMD_WR_CRAD, 3, 4);
    insert_at(2, 2, 2);
    update_at(n_occ, 2, 0, 100);
    update_at(n_occ, 1, 1, 100);
    insert_at(1, 2, 3);
    update_at(n_occ, 2, 0, 100);
    write_grid(0, 255);
    write_grid(128, 128);
  endtask

  task automatic test_random(int count);
    lbd_item_t it;
    int sp;
    for (int i = 0; i < count; i++) begin
      it = rand_item();
      sp = $urandom_range(7);
      case ($urandom_range(19))
        0, 1, 2, 3: begin
          it.cmd = CMD_INSERT;
          it.row = COORD_W'($urandom_range(rows_used + 1));
          it.col = COORD_W'($urandom_range(cols_used + 1));
          it.species = ($urandom_range(9) == 0) ? it.species : SPECIES_W'(sp);
        end
        4: begin
          it.cmd = CMD_WR_PROB; it.species = SPECIES_W'(sp);
          it.prob_death = PROB_W'($urandom_range(20000));
          it.prob_birth = PROB_W'($urandom_range(30000));
          it.prob_coag = PROB_W'($urandom_range(20000));
        end
        5: begin
          it.cmd = $urandom_range(1) ? CMD_WR_BRAD : CMD_WR_CRAD;
          it.species = SPECIES_W'(sp);
        end
        6: ;
        default: begin
          it.cmd = CMD_UPDATE;
          it.list_index = ($urandom_range(15) == 0) ? INDEX_W'($urandom_range(n_occ + 2))
                                                     : INDEX_W'($urandom_range(n_occ, 1));
          it.offset_row = OFFSET_W'($urandom_range(31) - 15);
          it.offset_col = OFFSET_W'($urandom_range(31) - 15);
          if ($urandom_range(2) == 0) begin
            it.offset_row = OFFSET_W'($urandom_range(6) - 3);
            it.offset_col = OFFSET_W'($urandom_range(6) - 3);
          end
        end
      endcase
      send_cmd(it);
    end
  endtask

  always @(posedge clk) begin
    lbd_expect_t e;
    if (rst_n) begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer status=%0d", out_ch.status);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (out_ch.status != e.status) begin
            $error("status expected %0d actual %0d", e.status, out_ch.status);
            errors++;
          end
          if (out_ch.occupied_count != e.count) begin
            $error("occupied_count expected %0d actual %0d", e.count,
                   out_ch.occupied_count);
            errors++;
          end
          if (out_ch.target_row != e.trow) begin
            $error("target_row expected %0d actual %0d", e.trow, out_ch.target_row);
            errors++;
          end
          if (out_ch.target_col != e.tcol) begin
            $error("target_col expected %0d actual %0d", e.tcol, out_ch.target_col);
            errors++;
          end
          if (e.status < 12) status_hits[e.status]++;
          n_checked++;
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int hit_kinds;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0; in_ch.row = '0; in_ch.col = '0; in_ch.species = '0;
    in_ch.list_index = '0; in_ch.draw = '0; in_ch.offset_row = '0;
    in_ch.offset_col = '0; in_ch.prob_death = '0; in_ch.prob_birth = '0;
    in_ch.prob_coag = '0; in_ch.radius = '0;
    out_ch.ready = 1'b0;
    rows_used = LBD_MAX_SIDE;
    cols_used = LBD_MAX_SIDE;
    n_occ = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_gap_pct = 12; recv_stall_pct = 77;
    test_directed();
    test_grid_extremes();
    write_grid(6, 5);
    test_random(450);
    send_gap_pct = 77; recv_stall_pct = 12;
    write_grid(128, 7);
    test_random(450);
    send_gap_pct = 0; recv_stall_pct = 0;
    write_grid(3, 128);
    test_random(450);
    drain_and_settle();
    hit_kinds = 0;
    foreach (status_hits[k]) if (status_hits[k] != 0) hit_kinds++;
    $display("Covered %0d items, %0d results checked, %0d of 12 status kinds seen.",
             n_sent, n_checked, hit_kinds);
    if (errors == 0 && pending_results.size() == 0 && !timed_out) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    wait (rst_n);
    wait (idle_cycles >= WATCHDOG);
    timed_out = 1;
    $display("FAIL");
    $finish;
  end
endmodule
